### rtl/core/ovseq_pkg.sv
// ----------------------------------------------------------------------------
// Overlay register sequencer package
// Shared types, register codes and constants of the overlay sequencer.
// ----------------------------------------------------------------------------
package ovseq_pkg;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;
    localparam int SEL_W     = 3;
    localparam int POS_W     = 11;
    localparam int PITCH_W   = 14;
    localparam int OFFSET_W  = 26;
    localparam int ADDR_LSB  = 4;
    localparam int QUOT_W    = 12;
    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [31:0] CTRL_FIXED    = 32'h0007_0304;
    localparam logic [31:0] PLANE_ENABLE  = 32'h0000_0004;
    localparam logic [1:0]  FMT_RGB565    = 2'd1;
    localparam logic [1:0]  CTRL_FMT_RGB  = 2'd1;
    localparam logic [1:0]  CTRL_FMT_YUV  = 2'd3;

    typedef enum logic [SEL_W-1:0] {
        SEL_CONTROL      = 3'd0,
        SEL_START        = 3'd1,
        SEL_END          = 3'd2,
        SEL_WIDTHS       = 3'd3,
        SEL_TOP_LEFT     = 3'd4,
        SEL_BOTTOM_RIGHT = 3'd5,
        SEL_SCALE        = 3'd6,
        SEL_INIT_SCALE   = 3'd7
    } t_reg_sel;

    typedef enum logic {
        AXIS_H = 1'b0,
        AXIS_V = 1'b1
    } t_axis;

    typedef struct packed {
        logic     load;
        logic     commit_addr;
        logic     div_start;
        t_axis    div_axis;
        logic     emit;
        t_reg_sel sel;
        logic     last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_hide;
        logic is_skip;
        logic is_same;
        logic div_done;
        logic div_busy;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/ovseq_div.sv
// ----------------------------------------------------------------------------
// Overlay scale divider
// Restoring divider for (num * 4096) / den with num <= den, one bit per cycle.
// ----------------------------------------------------------------------------
module ovseq_div
    import ovseq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [POS_W-1:0]  i_num,
    input  logic [POS_W-1:0]  i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [POS_W-1:0]     r_rem;
    logic [POS_W-1:0]     r_den;
    logic [QUOT_W-1:0]    r_quot;
    logic [POS_W:0]       w_shift;
    logic [POS_W:0]       w_diff;
    logic                 w_ge;

    // The remainder always stays below the divisor, so the doubled value
    // needs one bit more. A zero divisor only occurs with a zero numerator.
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (r_den != '0) && (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= (i_num == i_den) ? '0 : i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[POS_W-1:0] : w_shift[POS_W-1:0];
            r_quot <= {r_quot[QUOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### rtl/core/ovseq_dp.sv
// ----------------------------------------------------------------------------
// Overlay sequencer datapath
// Request capture, plane state, scale division and the output register.
// ----------------------------------------------------------------------------
module ovseq_dp
    import ovseq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [S_TDATA_W-1:0] i_req_data,
    input  logic                 i_req_hide,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [M_TDATA_W-1:0] o_out_value,
    output logic [SEL_W-1:0]     o_out_sel,
    output logic                 o_out_last
);

    logic                           r_hide;
    logic [OFFSET_W-1:0]            r_offset;
    logic [PITCH_W-1:0]             r_pitch;
    logic [POS_W-1:0]               r_sw;
    logic [POS_W-1:0]               r_sh;
    logic [POS_W-1:0]               r_left;
    logic [POS_W-1:0]               r_top;
    logic [POS_W-1:0]               r_ww;
    logic [POS_W-1:0]               r_wh;
    logic [1:0]                     r_fmt;
    logic [PITCH_W+POS_W-1:0]       r_prod;
    logic [OFFSET_W-ADDR_LSB-1:0]   r_start_addr;
    logic [M_TDATA_W-1:0]           r_shadow;
    t_axis                          r_axis;
    logic [QUOT_W-1:0]              r_hq;
    logic [QUOT_W-1:0]              r_vq;
    logic                           r_hs;
    logic                           r_vs;
    logic                           r_out_valid;
    logic [M_TDATA_W-1:0]           r_out_value;
    t_reg_sel                       r_out_sel;
    logic                           r_out_last;

    logic [POS_W-1:0]    w_src;
    logic [POS_W-1:0]    w_dst;
    logic                w_shrink;
    logic [POS_W-1:0]    w_start_src;
    logic [POS_W-1:0]    w_start_dst;
    logic                w_start_shrink;
    logic                w_div_busy;
    logic                w_div_done;
    logic [QUOT_W-1:0]   w_quot;
    logic [OFFSET_W:0]   w_end_sum;
    logic [POS_W:0]      w_wunits;
    logic [POS_W-1:0]    w_bottom;
    logic [POS_W-1:0]    w_right;
    logic [1:0]          w_fmt_code;
    logic [M_TDATA_W-1:0] w_value;
    logic                w_out_free;

    assign w_src    = (r_axis == AXIS_H) ? r_sw : r_sh;
    assign w_dst    = (r_axis == AXIS_H) ? r_ww : r_wh;
    assign w_shrink = (w_dst < w_src);

    // The axis being started is taken from the command, not from r_axis.
    assign w_start_src    = (i_cmd.div_axis == AXIS_H) ? r_sw : r_sh;
    assign w_start_dst    = (i_cmd.div_axis == AXIS_H) ? r_ww : r_wh;
    assign w_start_shrink = (w_start_dst < w_start_src);

    ovseq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_start_shrink ? w_start_dst : w_start_src),
        .i_den   (w_start_shrink ? w_start_src : w_start_dst),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hide   <= i_req_hide;
            r_offset <= i_req_data[25:0];
            r_pitch  <= i_req_data[39:26];
            r_sw     <= i_req_data[50:40];
            r_sh     <= i_req_data[61:51];
            r_left   <= i_req_data[72:62];
            r_top    <= i_req_data[83:73];
            r_ww     <= i_req_data[94:84];
            r_wh     <= i_req_data[105:95];
            r_fmt    <= i_req_data[107:106];
        end
        r_prod <= r_pitch * r_sh;
        if (w_div_done) begin
            if (r_axis == AXIS_H) begin
                r_hq <= w_quot;
                r_hs <= w_shrink;
            end else begin
                r_vq <= w_quot;
                r_vs <= w_shrink;
            end
        end
        if (i_cmd.emit) begin
            r_out_value <= w_value;
            r_out_sel   <= i_cmd.sel;
            r_out_last  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= '0;
            r_shadow     <= '0;
            r_axis       <= AXIS_H;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit_addr) begin
                r_start_addr <= r_offset[OFFSET_W-1:ADDR_LSB];
            end
            if (i_cmd.div_start) begin
                r_axis <= i_cmd.div_axis;
            end
            if (i_cmd.emit && (i_cmd.sel == SEL_CONTROL)) begin
                r_shadow <= w_value;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_end_sum  = {1'b0, r_offset} + (OFFSET_W+1)'(r_prod) - (OFFSET_W+1)'(1);
    assign w_wunits   = {1'b0, r_sw} + (POS_W+1)'(7);
    assign w_bottom   = r_top + r_wh;
    assign w_right    = r_left + r_ww;
    assign w_fmt_code = (r_fmt == FMT_RGB565) ? CTRL_FMT_RGB : CTRL_FMT_YUV;

    always_comb begin
        unique case (i_cmd.sel)
            SEL_CONTROL: begin
                if (r_hide) begin
                    w_value = r_shadow & ~PLANE_ENABLE;
                end else begin
                    w_value = CTRL_FIXED | {30'b0, w_fmt_code};
                end
            end
            SEL_START:        w_value = {6'b0, r_offset[OFFSET_W-1:ADDR_LSB], 4'b0};
            SEL_END:          w_value = {6'b0, w_end_sum[OFFSET_W-1:ADDR_LSB], 4'b0};
            SEL_WIDTHS:       w_value = {3'b0, w_wunits[POS_W:3], 6'b0,
                                         r_pitch[PITCH_W-1:ADDR_LSB], 4'b0};
            SEL_TOP_LEFT:     w_value = {5'b0, r_top, 5'b0, r_left};
            SEL_BOTTOM_RIGHT: w_value = {5'b0, w_bottom, 5'b0, w_right};
            SEL_SCALE:        w_value = {r_vs, 3'b0, r_vq, r_hs, 3'b0, r_hq};
            SEL_INIT_SCALE:   w_value = '0;
            default:          w_value = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_status.is_hide  = r_hide;
    assign o_status.is_skip  = !r_hide && (r_offset == '0);
    assign o_status.is_same  = (r_offset[OFFSET_W-1:ADDR_LSB] == r_start_addr);
    assign o_status.div_done = w_div_done;
    assign o_status.div_busy = w_div_busy;
    assign o_status.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_sel   = r_out_sel;
    assign o_out_last  = r_out_last;

endmodule

### rtl/core/ovseq_ctrl.sv
// ----------------------------------------------------------------------------
// Overlay sequencer controller
// Decodes each request and steps the datapath through its register writes.
// ----------------------------------------------------------------------------
module ovseq_ctrl
    import ovseq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVAL  = 5'b00010,
        S_DIV_H = 5'b00100,
        S_DIV_V = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_reg_sel r_sel;
    t_reg_sel n_sel;
    t_reg_sel r_last_sel;
    t_reg_sel n_last_sel;

    function automatic t_reg_sel next_sel(input t_reg_sel sel);
        t_reg_sel nxt;
        unique case (sel)
            SEL_START:        nxt = SEL_END;
            SEL_END:          nxt = SEL_WIDTHS;
            SEL_WIDTHS:       nxt = SEL_TOP_LEFT;
            SEL_TOP_LEFT:     nxt = SEL_BOTTOM_RIGHT;
            SEL_BOTTOM_RIGHT: nxt = SEL_SCALE;
            SEL_SCALE:        nxt = SEL_INIT_SCALE;
            SEL_INIT_SCALE:   nxt = SEL_CONTROL;
            SEL_CONTROL:      nxt = SEL_CONTROL;
            default:          nxt = SEL_CONTROL;
        endcase
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= SEL_CONTROL;
            r_last_sel <= SEL_CONTROL;
        end else begin
            r_state    <= n_state;
            r_sel      <= n_sel;
            r_last_sel <= n_last_sel;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_last_sel  = r_last_sel;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        o_cmd.sel   = r_sel;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (i_status.is_hide) begin
                    n_sel      = SEL_CONTROL;
                    n_last_sel = SEL_CONTROL;
                    n_state    = S_EMIT;
                end else if (i_status.is_skip) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.commit_addr = !i_status.is_same;
                    o_cmd.div_start   = 1'b1;
                    o_cmd.div_axis    = AXIS_H;
                    n_sel      = i_status.is_same ? SEL_TOP_LEFT : SEL_START;
                    n_last_sel = i_status.is_same ? SEL_SCALE : SEL_CONTROL;
                    n_state    = S_DIV_H;
                end
            end
            S_DIV_H: begin
                if (i_status.div_done) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_axis  = AXIS_V;
                    n_state         = S_DIV_V;
                end
            end
            S_DIV_V: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_sel == r_last_sel);
                    if (r_sel == r_last_sel) begin
                        n_state = S_IDLE;
                    end else begin
                        n_sel = next_sel(r_sel);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/video_overlay_register_sequencer.sv
// A hide request gives a single control write. A configure request with a
// zero buffer offset gives none; any other runs two scale divisions on one
// shared divider, then its writes follow at one write per cycle (3 or 8
// writes) while the output is not stalled. Requests are handled one at a time.
// Reset is synchronous, active low, and clears the start address and the
// control shadow to zero.
// ----------------------------------------------------------------------------
// Video overlay register sequencer
// Turns overlay requests into bursts of plane register writes.
// ----------------------------------------------------------------------------
module video_overlay_register_sequencer
    import ovseq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Fields from bit 0: buffer_offset, row_pitch, src_width, src_height,
    // win_left, win_top, win_width, win_height, pixel_format, zero fill.
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: command.
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Fields from bit 0: reg_value.
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: reg_select.
    output logic [SEL_W-1:0]     m_axis_tuser,
    output logic                 m_axis_tlast
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    ovseq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ovseq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_data  (s_axis_tdata),
        .i_req_hide  (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (m_axis_tdata),
        .o_out_sel   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_status.div_busy)
        else $error("Request accepted while the divider is busy.");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tuser == SEL_SCALE || m_axis_tuser == SEL_CONTROL))
        else $error("Final write of a request is neither scale nor control.");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> !$past(w_cmd.emit) || $past(m_axis_tvalid) == 1'b0)
        else $error("Output register overwritten while stalled.");
`endif

endmodule

### tb/sv/tb_video_overlay_register_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Overlay register sequencer testbench
// Sends hide and configure requests with random gaps. Output stalls are also
// random. Each register write is checked in order against a behavioral
// prediction of the plane state and write sequences.
// ----------------------------------------------------------------------------
module tb_video_overlay_register_sequencer
    import ovseq_pkg::*;
();

    localparam logic        CMD_CONFIGURE    = 1'b0;
    localparam logic        CMD_HIDE         = 1'b1;
    localparam logic [25:0] START_ADDR_MASK  = 26'h3FF_FFF0;
    localparam logic [31:0] CTRL_BASE        = 32'h0007_0304;
    localparam int          RANDOM_REQUESTS  = 320;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [10:0] wh;
        logic [10:0] ww;
        logic [10:0] top;
        logic [10:0] left;
        logic [10:0] sh;
        logic [10:0] sw;
        logic [13:0] pitch;
        logic [25:0] offset;
    } t_overlay_fields;

    typedef struct packed {
        logic            cmd;
        t_overlay_fields f;
    } t_request;

    typedef struct {
        t_reg_sel    sel;
        logic [31:0] value;
        logic        last;
    } t_reg_write;

    class overlay_write_scoreboard;
        logic [25:0] start_addr;
        logic [31:0] control_shadow;
        t_reg_write  write_q[$];
        int          err_count;
        int          write_count;
        int          full_count;
        int          short_count;
        int          hide_count;
        int          idle_count;

        function new();
            start_addr     = '0;
            control_shadow = '0;
            err_count      = 0;
            write_count    = 0;
            full_count     = 0;
            short_count    = 0;
            hide_count     = 0;
            idle_count     = 0;
        endfunction

        function int pending();
            return write_q.size();
        endfunction

        function void push_write(t_reg_sel sel, logic [31:0] value);
            t_reg_write w;
            w.sel   = sel;
            w.value = value;
            w.last  = 1'b0;
            write_q.push_back(w);
        endfunction

        // Returns the shrink flag above a 12-bit quotient.
        function logic [12:0] axis_ratio(logic [10:0] src, logic [10:0] dst);
            int unsigned q;
            if (dst >= src) begin
                if (dst == 0) begin
                    return 13'd0;
                end
                q = (int'(src) * 4096) / int'(dst);
                return {1'b0, q[11:0]};
            end
            q = (int'(dst) * 4096) / int'(src);
            return {1'b1, q[11:0]};
        endfunction

        function void push_window(t_overlay_fields f);
            logic [10:0] bottom;
            logic [10:0] right;
            logic [12:0] h;
            logic [12:0] v;
            bottom = f.top + f.wh;
            right  = f.left + f.ww;
            h      = axis_ratio(f.sw, f.ww);
            v      = axis_ratio(f.sh, f.wh);
            push_write(SEL_TOP_LEFT, {5'd0, f.top, 5'd0, f.left});
            push_write(SEL_BOTTOM_RIGHT, {5'd0, bottom, 5'd0, right});
            push_write(SEL_SCALE, {v[12], 3'd0, v[11:0], h[12], 3'd0, h[11:0]});
        endfunction

        function void note_request(t_request r);
            int          queued_n;
            logic [25:0] target;
            logic [31:0] end_addr;
            logic [31:0] units;
            queued_n = write_q.size();
            target   = r.f.offset & START_ADDR_MASK;
            if (r.cmd == CMD_HIDE) begin
                control_shadow = control_shadow & ~PLANE_ENABLE;
                push_write(SEL_CONTROL, control_shadow);
                hide_count++;
            end else if (r.f.offset == '0) begin
                idle_count++;
            end else if (target == start_addr) begin
                push_window(r.f);
                short_count++;
            end else begin
                start_addr = target;
                push_write(SEL_START, {6'd0, target});
                end_addr = 32'(r.f.offset) + 32'(r.f.pitch) * 32'(r.f.sh) - 32'd1;
                push_write(SEL_END, end_addr & {6'd0, START_ADDR_MASK});
                units = (32'(r.f.sw) * 2 + 15) / 16;
                push_write(SEL_WIDTHS, {2'd0, units[9:0], 6'd0, r.f.pitch[13:4], 4'd0});
                push_window(r.f);
                push_write(SEL_INIT_SCALE, 32'd0);
                control_shadow = CTRL_BASE | ((r.f.fmt == FMT_RGB565) ?
                                 32'(CTRL_FMT_RGB) : 32'(CTRL_FMT_YUV));
                push_write(SEL_CONTROL, control_shadow);
                full_count++;
            end
            if (write_q.size() > queued_n) begin
                write_q[write_q.size() - 1].last = 1'b1;
            end
        endfunction

        function void check_write(logic [2:0] sel, logic [31:0] value, logic last);
            t_reg_write w;
            if (write_q.size() == 0) begin
                err_count++;
                $display("%0t: unexpected write sel=%0d value=%08h last=%0b",
                         $time, sel, value, last);
                return;
            end
            w = write_q.pop_front();
            write_count++;
            if (sel !== w.sel || value !== w.value || last !== w.last) begin
                err_count++;
                $display("%0t: write mismatch: expected sel=%0d value=%08h last=%0b,",
                         $time, w.sel, w.value, w.last);
                $display("%0t:                 got sel=%0d value=%08h last=%0b",
                         $time, sel, value, last);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [SEL_W-1:0]     m_axis_tuser;
    logic                 m_axis_tlast;

    overlay_write_scoreboard sb = new();
    t_request                accepted_req;
    bit                      src_calm = 1'b0;
    logic [25:0]             last_target = '0;

    video_overlay_register_sequencer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 70) begin
            return $urandom_range(1, 3);
        end else if (k < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [10:0] rand_size();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            return 11'd0;
        end else if (k < 5) begin
            return 11'($urandom_range(1, 63));
        end
        return 11'($urandom_range(0, 2047));
    endfunction

    function automatic t_overlay_fields rand_fields();
        t_overlay_fields f;
        f.offset = 26'($urandom);
        f.pitch  = 14'($urandom);
        f.sw     = 11'($urandom);
        f.sh     = 11'($urandom);
        f.left   = 11'($urandom);
        f.top    = 11'($urandom);
        f.ww     = 11'($urandom);
        f.wh     = 11'($urandom);
        f.fmt    = 2'($urandom_range(0, 3));
        return f;
    endfunction

    function automatic t_request make_req(logic cmd, logic [25:0] offset, logic [13:0] pitch,
                                          logic [10:0] sw, logic [10:0] sh,
                                          logic [10:0] left, logic [10:0] top,
                                          logic [10:0] ww, logic [10:0] wh,
                                          logic [1:0] fmt);
        t_request r;
        r.cmd      = cmd;
        r.f.offset = offset;
        r.f.pitch  = pitch;
        r.f.sw     = sw;
        r.f.sh     = sh;
        r.f.left   = left;
        r.f.top    = top;
        r.f.ww     = ww;
        r.f.wh     = wh;
        r.f.fmt    = fmt;
        return r;
    endfunction

    // Mostly well-formed configure requests, new or at the current address,
    // mixed with hides, requests without a buffer and raw noise.
    function automatic t_request rand_request(logic [25:0] cur_target);
        t_request r;
        int       k;
        k     = $urandom_range(0, 99);
        r.cmd = CMD_CONFIGURE;
        r.f   = rand_fields();
        if (k < 70) begin
            if ($urandom_range(0, 4) == 0) begin
                r.f.pitch = 14'($urandom_range(0, 255));
            end
            r.f.sw = rand_size();
            r.f.sh = rand_size();
            r.f.ww = ($urandom_range(0, 3) == 0) ? r.f.sw : rand_size();
            r.f.wh = ($urandom_range(0, 3) == 0) ? r.f.sh : rand_size();
        end
        if (k < 50) begin
            if ($urandom_range(0, 19) == 0) begin
                r.f.offset = 26'($urandom_range(1, 15));
            end
            while (r.f.offset == '0 || (r.f.offset & START_ADDR_MASK) == cur_target) begin
                r.f.offset = 26'($urandom);
            end
        end else if (k < 70) begin
            r.f.offset = cur_target | 26'($urandom_range(0, 15));
            if (r.f.offset == '0) begin
                r.f.offset = 26'($urandom_range(1, 15));
            end
        end else if (k < 82) begin
            r.cmd = CMD_HIDE;
        end else if (k < 87) begin
            r.f.offset = '0;
        end else begin
            r.cmd = 1'($urandom);
        end
        return r;
    endfunction

    task automatic send_request(input t_request r);
        int gap;
        gap = (src_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {4'd0, r.f};
        do @(posedge i_clk); while (!s_axis_tready);
        if (r.cmd == CMD_CONFIGURE && r.f.offset != '0) begin
            last_target = r.f.offset & START_ADDR_MASK;
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            accepted_req.cmd = s_axis_tuser;
            accepted_req.f   = t_overlay_fields'(s_axis_tdata[107:0]);
            sb.note_request(accepted_req);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_write(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        int stall;
        int calm_left;
        stall     = 0;
        calm_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 99) < 25) begin
                    stall = pick_gap();
                end else if ($urandom_range(0, 99) < 3) begin
                    calm_left = $urandom_range(30, 150);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_request r;
        int       sent;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Hide right after reset writes an all-zero control word.
        send_request(make_req(CMD_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // An offset below 16 masks to the reset start address.
        send_request(make_req(CMD_CONFIGURE, 5, 100, 640, 480, 10, 20, 320, 960, 0));
        send_request(make_req(CMD_CONFIGURE, 0, 16383, 2047, 2047, 2047, 2047, 2047, 2047, 2));
        send_request(make_req(CMD_CONFIGURE, 26'h3FF_FFFF, 16383, 2047, 2047,
                              2047, 2047, 2047, 2047, 1));
        send_request(make_req(CMD_CONFIGURE, 26'h3FF_FFF3, 32, 1000, 100, 2047, 0, 10, 2047, 0));
        send_request(make_req(CMD_HIDE, 26'h3FF_FFFF, 16383, 2047, 2047,
                              2047, 2047, 2047, 2047, 3));
        send_request(make_req(CMD_CONFIGURE, 16, 0, 0, 0, 0, 0, 0, 0, 2));
        send_request(make_req(CMD_CONFIGURE, 31, 4096, 1280, 720, 100, 50, 1280, 720, 1));
        send_request(make_req(CMD_CONFIGURE, 26'h123_4567, 1234, 1, 1, 7, 9, 2047, 2047, 3));
        send_request(make_req(CMD_CONFIGURE, 26'h123_456F, 1234, 2047, 0, 0, 0, 0, 5, 3));
        send_request(make_req(CMD_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(CMD_CONFIGURE, 26'h200_0000, 15, 9, 2, 0, 0, 8, 1, 1));
        send_request(make_req(CMD_CONFIGURE, 26'h200_0008, 16, 8, 1, 0, 0, 9, 2, 1));
        send_request(make_req(CMD_CONFIGURE, 1, 1, 1, 1, 1, 1, 1, 1, 0));
        send_request(make_req(CMD_CONFIGURE, 15, 2, 2, 2, 2, 2, 2, 2, 0));
        send_request(make_req(CMD_CONFIGURE, 26'h0AB_CDE0, 8191, 1023, 511,
                              2000, 1900, 100, 300, 2));
        send_request(make_req(CMD_HIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        wait_until_drained();

        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (sent % 40 == 0) begin
                src_calm = ($urandom_range(0, 3) == 0);
            end
            if (sent == RANDOM_REQUESTS / 2) begin
                wait_until_drained();
            end
            r = rand_request(last_target);
            send_request(r);
            if (r.cmd == CMD_HIDE || r.f.offset != '0) begin
                sent++;
            end
        end

        wait_until_drained();
        repeat (60) @(posedge i_clk);
        $display("Requests: %0d full, %0d short, %0d hide, %0d without buffer.",
                 sb.full_count, sb.short_count, sb.hide_count, sb.idle_count);
        $display("Register writes checked: %0d, errors: %0d.", sb.write_count, sb.err_count);
        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
